@@ src/jld_pkg.sv @@
// Shared definitions for the length-prefixed JPEG line deframer.
// Holds register indexes, reset values, marker bytes and the request kinds.
// No dependencies.
package jld_pkg;

  // Default values for the top-level parameters.
  localparam int MAX_LINE_BYTES_DEF  = 4096;
  localparam int STORE_ADDR_BITS_DEF = 24;

  // Field widths.
  localparam int LINE_BYTES_W = 13;
  localparam int STORE_W      = 24;
  localparam int LENGTH_W     = 16;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_INDEX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_BYTES     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STORE_CAPACITY = 1'd1;

  // Register reset values.
  localparam logic [LINE_BYTES_W-1:0] LINE_BYTES_RST     = 13'd1280;
  localparam logic [STORE_W-1:0]      STORE_CAPACITY_RST = 24'd1048576;

  // Shortest line that the block handles; shorter settings act as this.
  localparam logic [LINE_BYTES_W-1:0] MIN_LINE_BYTES = 13'd8;

  // End-of-image marker bytes.
  localparam logic [7:0] MARK_FIRST  = 8'hFF;
  localparam logic [7:0] MARK_SECOND = 8'hD9;

  // Request kinds on the input channel.
  typedef enum logic {
    REQ_SOF  = 1'b0,
    REQ_BYTE = 1'b1
  } req_kind_t;

endpackage

@@ src/jpeg_line_deframer.sv @@
// Top level of the length-prefixed JPEG line deframer.
// Depends on jld_pkg for register indexes, reset values and marker bytes.
//
// The block accepts one request per clock cycle. Each request waits in the input register and
// its result in the result register, with a single pass of compare, add and select logic
// between them. Each request is either a start of
// frame or one byte of a received line. A line opens with a big-endian 16-bit payload length
// (clamped to the line length less two), then the payload, then padding up to line_bytes.
// Payload bytes are handed out with consecutive frame-store addresses starting at zero. The
// stored stream is watched for the end marker FF D9, which may span lines; the frame ends on
// the last byte of the line that holds it. If a line's payload would take the stored count
// past store_capacity, the frame ends at once on the second length byte with overflow set and
// nothing of that line stored. After a frame ends, bytes are dropped until the next start of
// frame; the block also starts out dropping after reset. Only payload bytes and frame ends
// produce a result; start of frame, length bytes and padding are absorbed silently. A stalled
// result sits in the result register while the input register takes the next request, so the
// input side only stops when both are full. Configuration writes take effect at once and are
// meant for idle periods only.
module jpeg_line_deframer #(
  parameter int MAX_LINE_BYTES  = jld_pkg::MAX_LINE_BYTES_DEF,
  parameter int STORE_ADDR_BITS = jld_pkg::STORE_ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port.
  input  logic                            cfg_wr_en,
  input  logic [jld_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [jld_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Request channel.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [7:0]                      line_byte,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            store_valid,
  output logic [jld_pkg::STORE_W-1:0]     store_addr,
  output logic [7:0]                      store_data,
  output logic                            frame_done,
  output logic                            overflow,
  output logic [jld_pkg::STORE_W-1:0]     frame_size
);

  // Line position counter width and a common width for position comparisons.
  localparam int POS_W = $clog2(MAX_LINE_BYTES);
  localparam int CMP_W = ((POS_W > jld_pkg::LENGTH_W) ? POS_W : jld_pkg::LENGTH_W) + 1;

  // Upper clamp for the line length, limited to what the register can hold.
  localparam logic [jld_pkg::LINE_BYTES_W-1:0] MAX_EFF =
    (MAX_LINE_BYTES > 8191) ? 13'h1FFF : 13'(MAX_LINE_BYTES);

  // Store addresses keep only the low STORE_ADDR_BITS bits of the stored count.
  localparam int ADDR_KEEP = (STORE_ADDR_BITS < jld_pkg::STORE_W) ? STORE_ADDR_BITS
                                                                  : jld_pkg::STORE_W;
  localparam logic [jld_pkg::STORE_W-1:0] ADDR_MASK = 24'((64'd1 << ADDR_KEEP) - 64'd1);

  // Configuration registers.
  logic [jld_pkg::LINE_BYTES_W-1:0] line_bytes;
  logic [jld_pkg::STORE_W-1:0]      store_capacity;

  // Input register.
  logic       req_vld;
  logic       req_kind;
  logic [7:0] req_byte;

  // Deframer state.
  logic [jld_pkg::STORE_W-1:0]  stored_count;
  logic [POS_W-1:0]             line_position;
  logic [jld_pkg::LENGTH_W-1:0] payload_length;
  logic [7:0]                   length_high_byte;
  logic [7:0]                   previous_byte;
  logic                         previous_valid;
  logic                         end_pending;
  logic                         dropping;

  logic [jld_pkg::STORE_W-1:0]  stored_count_next;
  logic [POS_W-1:0]             line_position_next;
  logic [jld_pkg::LENGTH_W-1:0] payload_length_next;
  logic [7:0]                   length_high_byte_next;
  logic [7:0]                   previous_byte_next;
  logic                         previous_valid_next;
  logic                         end_pending_next;
  logic                         dropping_next;

  // Result of the request in the input register.
  logic                        fire;
  logic                        res_produce;
  logic                        res_store;
  logic                        res_done;
  logic                        res_ovf;
  logic [jld_pkg::STORE_W-1:0] res_addr;

  // The request in the input register moves on once the result register is free or emptying.
  assign fire     = req_vld && (!out_valid || out_ready);
  assign in_ready = !req_vld || fire;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes     <= jld_pkg::LINE_BYTES_RST;
      store_capacity <= jld_pkg::STORE_CAPACITY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        jld_pkg::REG_LINE_BYTES:     line_bytes     <= cfg_data[jld_pkg::LINE_BYTES_W-1:0];
        jld_pkg::REG_STORE_CAPACITY: store_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else if (in_ready) begin
      req_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_kind <= req_type;
      req_byte <= line_byte;
    end
  end

  // Single-pass deframing of the registered request.
  always_comb begin
    logic [jld_pkg::LINE_BYTES_W-1:0] eff;
    logic [jld_pkg::LENGTH_W-1:0]     eff_m2;
    logic [jld_pkg::LENGTH_W-1:0]     len;
    logic [CMP_W-1:0]                 pos_x;
    logic [CMP_W-1:0]                 eff_x;
    logic                             last_pos;

    stored_count_next     = stored_count;
    line_position_next    = line_position;
    payload_length_next   = payload_length;
    length_high_byte_next = length_high_byte;
    previous_byte_next    = previous_byte;
    previous_valid_next   = previous_valid;
    end_pending_next      = end_pending;
    dropping_next         = dropping;
    res_store             = 1'b0;
    res_done              = 1'b0;
    res_ovf               = 1'b0;
    res_addr              = '0;

    if (line_bytes < jld_pkg::MIN_LINE_BYTES) begin
      eff = jld_pkg::MIN_LINE_BYTES;
    end else if (line_bytes > MAX_EFF) begin
      eff = MAX_EFF;
    end else begin
      eff = line_bytes;
    end
    eff_m2   = jld_pkg::LENGTH_W'(eff) - 16'd2;
    len      = {length_high_byte, req_byte};
    pos_x    = CMP_W'(line_position);
    eff_x    = CMP_W'(eff);
    last_pos = (pos_x >= eff_x - CMP_W'(1));

    if (req_kind == jld_pkg::REQ_SOF) begin
      stored_count_next   = '0;
      line_position_next  = '0;
      previous_valid_next = 1'b0;
      end_pending_next    = 1'b0;
      dropping_next       = 1'b0;
    end else if (!dropping) begin
      if (line_position == '0) begin
        length_high_byte_next = req_byte;
      end else if (line_position == POS_W'(1)) begin
        if (len > eff_m2) begin
          len = eff_m2;
        end
        payload_length_next = len;
        if ((25'(stored_count) + 25'(len)) > 25'(store_capacity)) begin
          res_done = 1'b1;
          res_ovf  = 1'b1;
        end
      end else if (pos_x < CMP_W'(payload_length) + CMP_W'(2)) begin
        res_store           = 1'b1;
        res_addr            = stored_count & ADDR_MASK;
        stored_count_next   = stored_count + 24'd1;
        if (previous_valid && previous_byte == jld_pkg::MARK_FIRST &&
            req_byte == jld_pkg::MARK_SECOND) begin
          end_pending_next = 1'b1;
        end
        previous_byte_next  = req_byte;
        previous_valid_next = 1'b1;
      end

      // Line wrap; a marker seen anywhere in this or an earlier line ends the frame here.
      if (!res_ovf) begin
        if (last_pos) begin
          line_position_next = '0;
          if (end_pending_next) begin
            res_done = 1'b1;
          end
        end else begin
          line_position_next = line_position + POS_W'(1);
        end
      end
      if (res_done) begin
        dropping_next      = 1'b1;
        line_position_next = '0;
      end
    end
  end

  assign res_produce = res_store || res_done;

  // State update.
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count     <= '0;
      line_position    <= '0;
      payload_length   <= '0;
      length_high_byte <= '0;
      previous_byte    <= '0;
      previous_valid   <= 1'b0;
      end_pending      <= 1'b0;
      dropping         <= 1'b1;
    end else if (fire) begin
      stored_count     <= stored_count_next;
      line_position    <= line_position_next;
      payload_length   <= payload_length_next;
      length_high_byte <= length_high_byte_next;
      previous_byte    <= previous_byte_next;
      previous_valid   <= previous_valid_next;
      end_pending      <= end_pending_next;
      dropping         <= dropping_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= res_produce;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_produce) begin
      store_valid <= res_store;
      store_addr  <= res_addr;
      store_data  <= res_store ? req_byte : 8'd0;
      frame_done  <= res_done;
      overflow    <= res_ovf;
      frame_size  <= stored_count_next;
    end
  end

  // An overflow always ends the frame and never stores.
  a_ovf_ends_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> frame_done && !store_valid)
    else $error("overflow result without frame end or with a store");

  // A frame end puts the block into dropping.
  a_done_drops: assert property (@(posedge clk) disable iff (rst)
    fire && res_done |=> dropping)
    else $error("frame ended but block not dropping");

  // Each stored byte advances the stored count by one.
  a_store_counts: assert property (@(posedge clk) disable iff (rst)
    fire && res_store |=> stored_count == $past(stored_count) + 24'd1)
    else $error("stored count did not advance on a store");

  // A held result must not be overwritten by the next request.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !fire)
    else $error("result register overwritten while stalled");

endmodule

@@ test/jpeg_line_deframer_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for jpeg_line_deframer: line framing, end marker and overflow.
// Predicts every store write and frame end in SystemVerilog and checks them in order.
// Depends on jld_pkg and jpeg_line_deframer from the source tree.
module jpeg_line_deframer_test;

  // One result of the block, with the fields in port order.
  typedef struct packed {
    logic                         store_valid;
    logic [jld_pkg::STORE_W-1:0]  store_addr;
    logic [7:0]                   store_data;
    logic                         frame_done;
    logic                         overflow;
    logic [jld_pkg::STORE_W-1:0]  frame_size;
  } store_op_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic [jld_pkg::CFG_INDEX_W-1:0] cfg_index = jld_pkg::REG_LINE_BYTES;
  logic [jld_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            req_type = jld_pkg::REQ_SOF;
  logic [7:0]                      line_byte = 8'h00;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            store_valid;
  logic [jld_pkg::STORE_W-1:0]     store_addr;
  logic [7:0]                      store_data;
  logic                            frame_done;
  logic                            overflow;
  logic [jld_pkg::STORE_W-1:0]     frame_size;

  jpeg_line_deframer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .line_byte  (line_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .store_valid(store_valid),
    .store_addr (store_addr),
    .store_data (store_data),
    .frame_done (frame_done),
    .overflow   (overflow),
    .frame_size (frame_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results that the block still owes us, oldest first.
  store_op_t expected_store_ops[$];
  int        failure_count = 0;

  // When set, both sides of the block idle in short random bursts.
  bit idling = 1'b1;
  // Cycles for which the result side is to hold off completely, counted down by the sink.
  int sink_hold_cycles = 0;
  // Requests that the block acts upon; requests that it ignores while dropping are not counted.
  int live_requests = 0;

  // Our own copy of the configuration and of the deframing state.
  logic [jld_pkg::LINE_BYTES_W-1:0] line_bytes_cfg = jld_pkg::LINE_BYTES_RST;
  logic [jld_pkg::STORE_W-1:0]      store_capacity_cfg = jld_pkg::STORE_CAPACITY_RST;
  logic [jld_pkg::STORE_W-1:0]      stored_count = '0;
  logic [11:0]                      line_pos = '0;
  logic [jld_pkg::LENGTH_W-1:0]     payload_len = '0;
  logic [7:0]                       len_high = '0;
  logic [7:0]                       prev_byte = '0;
  logic                             prev_valid = 1'b0;
  logic                             end_pending = 1'b0;
  logic                             dropping = 1'b1;

  // Settings below the minimum act as the minimum, and settings above the largest line act as
  // the largest line.
  function automatic int effective_line_length();
    if (line_bytes_cfg < jld_pkg::MIN_LINE_BYTES) return int'(jld_pkg::MIN_LINE_BYTES);
    if (line_bytes_cfg > jld_pkg::MAX_LINE_BYTES_DEF) return jld_pkg::MAX_LINE_BYTES_DEF;
    return int'(line_bytes_cfg);
  endfunction

  // Works out what one accepted request does to the frame and queues the result, if any.
  task automatic deframe_request(input jld_pkg::req_kind_t kind, input logic [7:0] data_byte);
    int unsigned eff;
    int unsigned pos;
    int unsigned len;
    store_op_t   op;
    op = '0;
    if (kind == jld_pkg::REQ_SOF) begin
      // A start of frame always restarts capture, abandoning any frame in progress.
      stored_count = '0;
      line_pos = '0;
      prev_valid = 1'b0;
      end_pending = 1'b0;
      dropping = 1'b0;
      live_requests++;
      return;
    end
    if (dropping) return;
    live_requests++;
    eff = effective_line_length();
    pos = 32'(line_pos);
    if (pos == 0) begin
      len_high = data_byte;
    end else if (pos == 1) begin
      len = 32'({len_high, data_byte});
      if (len > eff - 2) len = eff - 2;
      payload_len = jld_pkg::LENGTH_W'(len);
      // The whole line is refused if it would not fit in the store.
      if (stored_count + len > store_capacity_cfg) begin
        op.frame_done = 1'b1;
        op.overflow = 1'b1;
      end
    end else if (pos - 2 < payload_len) begin
      op.store_valid = 1'b1;
      op.store_addr = stored_count;
      op.store_data = data_byte;
      stored_count = stored_count + jld_pkg::STORE_W'(1);
      // The marker is looked for in the stored stream only, so padding never breaks it up.
      if (prev_valid && prev_byte == jld_pkg::MARK_FIRST && data_byte == jld_pkg::MARK_SECOND)
        end_pending = 1'b1;
      prev_byte = data_byte;
      prev_valid = 1'b1;
    end
    if (!op.overflow) begin
      if (pos >= eff - 1) begin
        line_pos = '0;
        if (end_pending) op.frame_done = 1'b1;
      end else begin
        line_pos = 12'(pos + 1);
      end
    end
    if (op.frame_done) begin
      dropping = 1'b1;
      line_pos = '0;
    end
    op.frame_size = stored_count;
    if (op.store_valid || op.frame_done) expected_store_ops.push_back(op);
  endtask

  // Offers one request and holds it until the block takes it.
  task automatic send_request(input jld_pkg::req_kind_t kind, input logic [7:0] data_byte);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    line_byte <= data_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_request(kind, data_byte);
  endtask

  // Mostly uniform bytes, with extra FF bytes so that near-markers turn up often.
  function automatic logic [7:0] random_byte();
    if ($urandom_range(0, 15) == 0) return jld_pkg::MARK_FIRST;
    return 8'($urandom_range(0, 255));
  endfunction

  // Sends one line with the given length prefix. A marker may be placed at a payload index,
  // or its second byte at the head of the payload so that it completes one begun on the line
  // before. Fewer bytes than the line holds may be sent, which leaves the line unfinished.
  task automatic send_line(input int length_field, input int mark_at, input bit lead_d9,
                           input int byte_count);
    int          eff;
    int          plen;
    int          p;
    logic [15:0] prefix;
    logic [7:0]  value;
    eff = effective_line_length();
    prefix = length_field[15:0];
    plen = (prefix > eff - 2) ? eff - 2 : int'(prefix);
    for (int k = 0; k < byte_count && k < eff; k++) begin
      p = k - 2;
      if (k == 0) value = prefix[15:8];
      else if (k == 1) value = prefix[7:0];
      else if (p < plen && lead_d9 && p == 0) value = jld_pkg::MARK_SECOND;
      else if (p < plen && mark_at >= 0 && p == mark_at) value = jld_pkg::MARK_FIRST;
      else if (p < plen && mark_at >= 0 && p == mark_at + 1) value = jld_pkg::MARK_SECOND;
      else value = random_byte();
      send_request(jld_pkg::REQ_BYTE, value);
    end
  endtask

  // Lets every owed result out, then waits a little longer for requests that produce none.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (expected_store_ops.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [jld_pkg::CFG_INDEX_W-1:0] index,
                                input logic [jld_pkg::CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    case (index)
      jld_pkg::REG_LINE_BYTES:     line_bytes_cfg = value[jld_pkg::LINE_BYTES_W-1:0];
      jld_pkg::REG_STORE_CAPACITY: store_capacity_cfg = value[jld_pkg::STORE_W-1:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Short lines with hand-picked bytes: dropping after reset, clamped length, a marker in the
  // middle of a line ending on a payload byte, a marker split across lines, a marker in padding.
  task automatic test_directed();
    logic [7:0] clamped_line[8] = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hD9, 8'h12, 8'h34, 8'hFF};
    logic [7:0] split_lines[16] = '{8'h00, 8'h01, 8'hFF, 8'hFF, 8'hD9, 8'h00, 8'h7E, 8'h80,
                                    8'h00, 8'h02, 8'hD9, 8'h55, 8'h01, 8'hFF, 8'hD9, 8'hFE};
    write_register(jld_pkg::REG_LINE_BYTES, jld_pkg::CFG_DATA_W'(jld_pkg::MIN_LINE_BYTES));
    write_register(jld_pkg::REG_STORE_CAPACITY, 24'hFFFFFF);
    // Reset leaves the block waiting for a start of frame, so these are ignored.
    send_request(jld_pkg::REQ_BYTE, 8'h00);
    send_request(jld_pkg::REQ_BYTE, 8'hFF);
    send_request(jld_pkg::REQ_SOF, 8'hA5);
    foreach (clamped_line[i]) send_request(jld_pkg::REQ_BYTE, clamped_line[i]);
    send_request(jld_pkg::REQ_SOF, 8'h5A);
    foreach (split_lines[i]) send_request(jld_pkg::REQ_BYTE, split_lines[i]);
    wait_until_idle();
  endtask

  // Store limits: the smallest capacities, an exact fit and a line one byte too long.
  task automatic test_store_overflow();
    write_register(jld_pkg::REG_LINE_BYTES, jld_pkg::CFG_DATA_W'(jld_pkg::MIN_LINE_BYTES));
    write_register(jld_pkg::REG_STORE_CAPACITY, jld_pkg::CFG_DATA_W'(1));
    send_request(jld_pkg::REQ_SOF, 8'h00);
    send_line(1, -1, 1'b0, 8);
    send_line(1, -1, 1'b0, 8);
    wait_until_idle();
    write_register(jld_pkg::REG_STORE_CAPACITY, jld_pkg::CFG_DATA_W'(0));
    send_request(jld_pkg::REQ_SOF, 8'h00);
    send_line(0, -1, 1'b0, 8);
    send_line(3, -1, 1'b0, 8);
    wait_until_idle();
    write_register(jld_pkg::REG_STORE_CAPACITY, jld_pkg::CFG_DATA_W'(7));
    send_request(jld_pkg::REQ_SOF, 8'h00);
    send_line(6, -1, 1'b0, 8);
    send_line(1, -1, 1'b0, 8);
    send_line(1, -1, 1'b0, 8);
    wait_until_idle();
  endtask

  // Settings changed while a frame is open.
  task automatic test_line_resize();
    write_register(jld_pkg::REG_LINE_BYTES, jld_pkg::CFG_DATA_W'(40));
    write_register(jld_pkg::REG_STORE_CAPACITY, 24'hFFFFFF);
    send_request(jld_pkg::REQ_SOF, 8'h00);
    send_line(32, 0, 1'b0, 20);
    wait_until_idle();
    // The line is now shorter than the position reached, so the next byte closes it, and the
    // marker seen earlier ends the frame on that same byte.
    write_register(jld_pkg::REG_LINE_BYTES, jld_pkg::CFG_DATA_W'(0));
    send_request(jld_pkg::REQ_BYTE, 8'h3C);
    send_request(jld_pkg::REQ_SOF, 8'h00);
    send_line(6, -1, 1'b0, 8);
    wait_until_idle();
    write_register(jld_pkg::REG_STORE_CAPACITY, jld_pkg::CFG_DATA_W'(8));
    send_line(3, -1, 1'b0, 8);
    wait_until_idle();
  endtask

  // The longest lines: a setting beyond the largest line and the largest line itself both clamp
  // a huge length to the largest payload, which the overflow check exposes one byte either side.
  // A short setting then closes the long line that was left open.
  task automatic test_line_extremes();
    write_register(jld_pkg::REG_LINE_BYTES, jld_pkg::CFG_DATA_W'(13'h1FFF));
    write_register(jld_pkg::REG_STORE_CAPACITY,
                   jld_pkg::CFG_DATA_W'(jld_pkg::MAX_LINE_BYTES_DEF - 3));
    send_request(jld_pkg::REQ_SOF, 8'h00);
    send_line(16'hFFFF, -1, 1'b0, 4);
    wait_until_idle();
    write_register(jld_pkg::REG_LINE_BYTES, jld_pkg::CFG_DATA_W'(jld_pkg::MAX_LINE_BYTES_DEF));
    write_register(jld_pkg::REG_STORE_CAPACITY,
                   jld_pkg::CFG_DATA_W'(jld_pkg::MAX_LINE_BYTES_DEF - 2));
    send_request(jld_pkg::REQ_SOF, 8'h00);
    send_line(5000, 0, 1'b0, 12);
    wait_until_idle();
    write_register(jld_pkg::REG_LINE_BYTES, jld_pkg::CFG_DATA_W'(jld_pkg::MIN_LINE_BYTES));
    send_request(jld_pkg::REQ_BYTE, 8'hC3);
    wait_until_idle();
  endtask

  // The result side stops for a long while, so the block fills and refuses further requests.
  task automatic test_result_backpressure();
    write_register(jld_pkg::REG_LINE_BYTES, jld_pkg::CFG_DATA_W'(40));
    write_register(jld_pkg::REG_STORE_CAPACITY, 24'hFFFFFF);
    idling = 1'b0;
    sink_hold_cycles = 60;
    send_request(jld_pkg::REQ_SOF, 8'h00);
    repeat (3) send_line(38, -1, 1'b0, 40);
    wait_until_idle();
    idling = 1'b1;
  endtask

  task automatic randomise_settings();
    int sel;
    wait_until_idle();
    sel = $urandom_range(0, 9);
    if (sel == 0)
      write_register(jld_pkg::REG_LINE_BYTES, jld_pkg::CFG_DATA_W'($urandom_range(0, 7)));
    else if (sel == 1)
      write_register(jld_pkg::REG_LINE_BYTES, jld_pkg::CFG_DATA_W'(jld_pkg::MIN_LINE_BYTES));
    else
      write_register(jld_pkg::REG_LINE_BYTES, jld_pkg::CFG_DATA_W'($urandom_range(9, 48)));
    if ($urandom_range(0, 9) < 3)
      write_register(jld_pkg::REG_STORE_CAPACITY, jld_pkg::CFG_DATA_W'($urandom_range(0, 150)));
    else
      write_register(jld_pkg::REG_STORE_CAPACITY,
                     jld_pkg::CFG_DATA_W'($urandom_range(151, 24'hFFFFFF)));
  endtask

  // A well-formed frame with random content, now and then broken off part way through a line.
  task automatic send_random_frame();
    int lines;
    int eff;
    int sel;
    int len_field;
    int plen;
    int mark_at;
    bit span;
    span = 1'b0;
    send_request(jld_pkg::REQ_SOF, random_byte());
    lines = $urandom_range(1, 5);
    for (int i = 0; i < lines && !dropping; i++) begin
      eff = effective_line_length();
      sel = $urandom_range(0, 9);
      if (sel == 0) len_field = 0;
      else if (sel == 1) len_field = eff - 2;
      else if (sel == 2) len_field = $urandom_range(eff - 1, 16'hFFFF);
      else len_field = $urandom_range(1, eff - 2);
      plen = (len_field > eff - 2) ? eff - 2 : len_field;
      mark_at = -1;
      if (plen >= 2 && $urandom_range(0, 2) == 0) mark_at = $urandom_range(0, plen - 2);
      else if (plen >= 1 && $urandom_range(0, 4) == 0) mark_at = plen - 1;
      send_line(len_field, mark_at, span,
                ($urandom_range(0, 24) == 0) ? $urandom_range(0, eff - 1) : eff);
      // An FF on the last payload byte is finished by a D9 opening the next payload.
      span = (plen >= 1 && mark_at == plen - 1);
    end
  endtask

  task automatic test_random_frames(input int target);
    int start_count;
    start_count = live_requests;
    while (live_requests - start_count < target) begin
      if ($urandom_range(0, 4) == 0) randomise_settings();
      // Stray bytes: ignored while dropping, otherwise they knock the line out of step.
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) send_request(jld_pkg::REQ_BYTE, random_byte());
      end
      send_random_frame();
    end
  endtask

  // Result sink: random stalls, plus a long hold-off when a test asks for one.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles != 0) begin
        out_ready <= 1'b0;
        sink_hold_cycles--;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Every result taken by the sink is compared with the oldest prediction.
  always @(posedge clk) begin
    store_op_t seen;
    store_op_t want;
    if (!rst && out_valid && out_ready) begin
      seen = '{store_valid, store_addr, store_data, frame_done, overflow, frame_size};
      if (expected_store_ops.size() == 0) begin
        failure_count++;
        if (failure_count <= 10) begin
          $display("unexpected result: valid=%0b addr=%0d data=%h done=%0b ovf=%0b size=%0d",
                   seen.store_valid, seen.store_addr, seen.store_data, seen.frame_done,
                   seen.overflow, seen.frame_size);
        end
      end else begin
        want = expected_store_ops.pop_front();
        if (seen.store_valid !== want.store_valid || seen.store_addr !== want.store_addr ||
            seen.store_data !== want.store_data || seen.frame_done !== want.frame_done ||
            seen.overflow !== want.overflow || seen.frame_size !== want.frame_size) begin
          failure_count++;
          if (failure_count <= 10) begin
            $display("result mismatch: expected valid=%0b addr=%0d data=%h done=%0b ovf=%0b size=%0d",
                     want.store_valid, want.store_addr, want.store_data, want.frame_done,
                     want.overflow, want.frame_size);
            $display("                 actual   valid=%0b addr=%0d data=%h done=%0b ovf=%0b size=%0d",
                     seen.store_valid, seen.store_addr, seen.store_data, seen.frame_done,
                     seen.overflow, seen.frame_size);
          end
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_store_overflow();
    test_line_resize();
    test_line_extremes();
    test_result_backpressure();
    test_random_frames(300);
    // The closing stretch runs at full rate on both sides.
    idling = 1'b0;
    test_random_frames(100);
    in_valid <= 1'b0;
    for (int n = 0; n < 20000 && expected_store_ops.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_store_ops.size() != 0) begin
      failure_count++;
      $display("%0d results never arrived", expected_store_ops.size());
    end
    if (failure_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
src/jld_pkg.sv
src/jpeg_line_deframer.sv
test/jpeg_line_deframer_test.sv
